FILE: sv/fdf_pkg.sv
// Package for the FIR derivative filter: widths, coefficient table, command and status types.
package fdf_pkg;

    localparam int TAPS_DEFAULT        = 29;
    localparam int SAMPLE_BITS_DEFAULT = 20;
    localparam int OUT_BITS            = 28;
    localparam int COEF_BITS           = 5;
    localparam int COEF_IDX_BITS       = 6;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture sample of the accepted transfer
        logic cnt_clr;    // clear tap counter
        logic fill_we;    // write sample into slot cnt
        logic slot_clr;   // ring pointer back to slot 0
        logic slot_write; // write sample at ring pointer, set up read sweep
        logic rd_en;      // read one tap
        logic emit;       // load output register
        logic emit_zero;  // output zero instead of accumulator
    } fdf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_last;
        logic pipe_busy;
        logic out_stall;
    } fdf_stat_t;

    // Coefficients, oldest sample first; taps past the table weigh zero.
    function automatic coef_t coef_at(input logic [COEF_IDX_BITS-1:0] idx);
        coef_t c;
        case (idx)
            6'd0:    c = -5'sd4;
            6'd1:    c = -5'sd7;
            6'd2:    c = -5'sd10;
            6'd3:    c = -5'sd11;
            6'd4:    c = -5'sd10;
            6'd5:    c = -5'sd9;
            6'd6:    c = -5'sd8;
            6'd7:    c = -5'sd7;
            6'd8:    c = -5'sd6;
            6'd9:    c = -5'sd5;
            6'd10:   c = -5'sd4;
            6'd11:   c = -5'sd3;
            6'd12:   c = -5'sd2;
            6'd13:   c = -5'sd1;
            6'd14:   c = 5'sd0;
            6'd15:   c = 5'sd1;
            6'd16:   c = 5'sd2;
            6'd17:   c = 5'sd3;
            6'd18:   c = 5'sd4;
            6'd19:   c = 5'sd5;
            6'd20:   c = 5'sd6;
            6'd21:   c = 5'sd7;
            6'd22:   c = 5'sd8;
            6'd23:   c = 5'sd9;
            6'd24:   c = 5'sd10;
            6'd25:   c = 5'sd11;
            6'd26:   c = 5'sd10;
            6'd27:   c = 5'sd7;
            6'd28:   c = 5'sd4;
            default: c = 5'sd0;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/fdf_stream_if.sv
// Valid/ready channel interfaces for the filter's sample input and result output.
interface fdf_req_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface fdf_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [27:0] slope_sum;

    modport source (output valid, output slope_sum, input ready);
    modport sink   (input valid, input slope_sum, output ready);
endinterface

FILE: sv/fdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 29
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fdf_ctrl.sv
// Controller state machine: sequences fill, ring write, tap sweep and result transfer.
module fdf_ctrl
    import fdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_kind,
    output logic      req_ready,
    input  fdf_stat_t stat,
    output fdf_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       primed_reg;
    logic       primed_next;
    logic       zero_reg;
    logic       zero_next;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next  = state_reg;
        primed_next = primed_reg;
        zero_next   = zero_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_kind == KIND_RESTART)
                    begin
                        primed_next = 1'b0;
                    end
                    else if (!primed_reg)
                    begin
                        cmd.load    = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_FILL;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_we = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.slot_clr = 1'b1;
                    primed_next  = 1'b1;
                    zero_next    = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_WRITE:
            begin
                cmd.slot_write = 1'b1;
                cmd.cnt_clr    = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    zero_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_stall)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_zero = zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            primed_reg <= 1'b0;
            zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            zero_reg   <= zero_next;
        end
    end

endmodule

FILE: sv/fdf_datapath.sv
// Datapath: history ring in RAM, tap counter, multiply-accumulate and output register.
module fdf_datapath
    import fdf_pkg::*;
#(
    parameter int TAPS        = TAPS_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdf_cmd_t                      cmd,
    output fdf_stat_t                     stat,
    input  logic signed [SAMPLE_BITS-1:0] req_sample,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic signed [OUT_BITS-1:0]    rsp_slope_sum
);

    localparam int AW = $clog2(TAPS);
    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [AW-1:0]                 slot_reg;
    logic [AW-1:0]                 slot_next;
    logic [AW-1:0]                 rd_addr_reg;
    logic [AW-1:0]                 rd_addr_next;
    logic [AW-1:0]                 cnt_reg;
    logic [AW-1:0]                 cnt_next;
    logic [AW-1:0]                 tap_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;
    logic signed [63:0]            prod_wide;
    logic signed [OUT_BITS-1:0]    acc_reg;
    logic signed [OUT_BITS-1:0]    acc_next;
    logic                          out_valid_reg;
    logic signed [OUT_BITS-1:0]    out_data_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    coef_t                         coef;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == LAST) ? '0 : x + 1'b1;
    endfunction

    assign ram_we    = cmd.fill_we || cmd.slot_write;
    assign ram_waddr = cmd.fill_we ? cnt_reg : slot_reg;

    fdf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        slot_next    = slot_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        if (cmd.slot_clr)
        begin
            slot_next = '0;
        end
        else if (cmd.slot_write)
        begin
            slot_next    = wrap_inc(slot_reg);
            rd_addr_next = wrap_inc(slot_reg);
        end
        else if (cmd.rd_en)
        begin
            rd_addr_next = wrap_inc(rd_addr_reg);
        end
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.fill_we || cmd.rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign coef      = coef_at(COEF_IDX_BITS'(tap_reg));
    assign prod_next = PW'($signed(ram_rdata)) * PW'(coef);
    assign prod_wide = 64'(prod_reg);
    assign acc_next  = acc_reg + prod_wide[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            rd_addr_reg   <= '0;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            rd_addr_reg <= rd_addr_next;
            cnt_reg     <= cnt_next;
            v1_reg      <= cmd.rd_en;
            v2_reg      <= v1_reg;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= req_sample;
        end
        tap_reg  <= cnt_reg;
        prod_reg <= prod_next;
        if (cmd.slot_write)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.emit)
        begin
            out_data_reg <= cmd.emit_zero ? '0 : acc_reg;
        end
    end

    assign stat.cnt_last  = (cnt_reg == LAST);
    assign stat.pipe_busy = v1_reg || v2_reg;
    assign stat.out_stall = out_valid_reg && !rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign rsp_slope_sum = out_data_reg;

endmodule

FILE: sv/fir_derivative_filter.sv
// Top level of the FIR derivative filter: controller, datapath and channel wiring.
//
// Channels: req carries one item per transfer, kind (sample or restart) and a
// signed sample in thousandths; rsp carries slope_sum, the 29-tap weighted sum
// of the sample history, which is the derivative times 96000.
// A restart transfer gives no result; the next sample refills the whole history
// with itself and returns zero. Later samples replace the oldest slot and return
// the tap sum, oldest sample times the first coefficient.
// Sequence for a sample: one ring write, then one read per tap through the single
// read port of the history RAM into a one-multiplier accumulate loop, a drain of
// the read/multiply pipeline, and the load of the output register; the next item
// is taken only after that, so a sample is done before the next is accepted.
// A first sample after restart gives its zero once the refill sweep has written
// it to every slot. A restart only marks the history unprimed.
// req.ready is high only while no item is in progress.
// Reset (rst_n, asynchronous, active low) clears the controller and marks the
// history unprimed; no clearing pass is needed.
// A result sits in an output register; while rsp stalls, the block still takes
// and works the next item and holds its result until the register frees up.
module fir_derivative_filter
    import fdf_pkg::*;
#(
    parameter int TAPS        = TAPS_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    fdf_req_if.sink   req,
    fdf_rsp_if.source rsp
);

    fdf_cmd_t  cmd;
    fdf_stat_t stat;

    fdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fdf_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_sample    (req.sample),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_slope_sum (rsp.slope_sum)
    );

endmodule
